>>> hdl/lobm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, field widths, codes and controller interface of the order book
// matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 64;

    localparam int OP_W      = 2;
    localparam int ID_W      = 64;
    localparam int PRICE_W   = 24;
    localparam int QTY_W     = 32;
    localparam int ARR_W     = 32;
    localparam int RKIND_W   = 3;
    localparam int CNT_OUT_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // result kinds
    localparam logic [RKIND_W-1:0] RK_TRADE   = 3'd0;
    localparam logic [RKIND_W-1:0] RK_ACCEPT  = 3'd1;
    localparam logic [RKIND_W-1:0] RK_DUP     = 3'd2;
    localparam logic [RKIND_W-1:0] RK_NOCROSS = 3'd3;
    localparam logic [RKIND_W-1:0] RK_FULL    = 3'd4;
    localparam logic [RKIND_W-1:0] RK_CANCEL  = 3'd5;
    localparam logic [RKIND_W-1:0] RK_UNKNOWN = 3'd6;
    localparam logic [RKIND_W-1:0] RK_SIDE    = 3'd7;

    // one resting order
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   rem;
        logic               kind;
    } t_slot;

    // one buffered result
    typedef struct packed {
        logic [RKIND_W-1:0] kind;
        logic [ID_W-1:0]    bid_id;
        logic [PRICE_W-1:0] bid_price;
        logic [ID_W-1:0]    ask_id;
        logic [PRICE_W-1:0] ask_price;
        logic [QTY_W-1:0]   qty;
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CHECK,
        ST_REN_LOAD,
        ST_REN_CAP,
        ST_REN_SCAN,
        ST_REN_STORE,
        ST_REN_COPY,
        ST_REN_WAIT,
        ST_WRITE_NEW,
        ST_MSTART,
        ST_MSCAN,
        ST_MDECIDE,
        ST_TRADE_B,
        ST_TRADE_A,
        ST_FINISH,
        ST_OUT_START,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic               scan_start;
        logic               scan_copy;
        logic               clr_found;
        logic               use_found_kind;
        logic               capture_free;
        logic               write_new;
        logic               ren_init;
        logic               ren_capture;
        logic               ren_store;
        logic               ren_finish;
        logic               trade_b;
        logic               trade_a;
        logic               finish;
        logic               push;
        logic [RKIND_W-1:0] push_kind;
        logic               buf_clear;
        logic               out_start;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic side_diff;
        logic kind;
        logic can_cross;
        logic free_ok;
        logic wrap;
        logic ren_last;
        logic cross_now;
        logic out_done;
    } t_stat;

endpackage

>>> hdl/lobm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer of the matcher: drives scans, checks, renumbering, trades and the
// result stream of one transaction at a time.
// ----------------------------------------------------------------------------
module lobm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [lobm_pkg::OP_W-1:0] i_operation,
    input  lobm_pkg::t_stat           i_stat,
    output lobm_pkg::t_cmd            o_cmd,
    output logic                      busy
);
    import lobm_pkg::*;

    t_state          r_state, n_state;
    logic [OP_W-1:0] r_op;
    logic            accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // state register and latched operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NONE;
        end else begin
            r_state <= n_state;
            if (accept) r_op <= i_operation;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (accept && i_operation != OP_NONE) n_state = ST_SCAN;
            ST_SCAN:      if (i_stat.scan_done) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_op == OP_ADD) begin
                    n_state = i_stat.found ? ST_OUT_START : ST_CHECK;
                end else if (r_op == OP_MODIFY) begin
                    n_state = (!i_stat.found || i_stat.side_diff) ? ST_OUT_START : ST_CHECK;
                end else begin
                    n_state = ST_OUT_START;
                end
            end
            ST_CHECK: begin
                if (i_stat.kind && !i_stat.can_cross) n_state = ST_OUT_START;
                else if (!i_stat.free_ok)             n_state = ST_OUT_START;
                else if (i_stat.wrap)                 n_state = ST_REN_LOAD;
                else                                  n_state = ST_WRITE_NEW;
            end
            ST_REN_LOAD:  n_state = ST_REN_CAP;
            ST_REN_CAP:   n_state = ST_REN_SCAN;
            ST_REN_SCAN:  if (i_stat.scan_done) n_state = ST_REN_STORE;
            ST_REN_STORE: n_state = i_stat.ren_last ? ST_REN_COPY : ST_REN_LOAD;
            ST_REN_COPY:  n_state = ST_REN_WAIT;
            ST_REN_WAIT:  if (i_stat.scan_done) n_state = ST_WRITE_NEW;
            ST_WRITE_NEW: n_state = ST_MSTART;
            ST_MSTART:    n_state = ST_MSCAN;
            ST_MSCAN:     if (i_stat.scan_done) n_state = ST_MDECIDE;
            ST_MDECIDE:   n_state = i_stat.cross_now ? ST_TRADE_B : ST_FINISH;
            ST_TRADE_B:   n_state = ST_TRADE_A;
            ST_TRADE_A:   n_state = ST_MSTART;
            ST_FINISH:    n_state = ST_OUT_START;
            ST_OUT_START: n_state = ST_OUT;
            ST_OUT:       if (i_stat.out_done) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                // an ignored operation must not start a scan
                if (accept && i_operation != OP_NONE) begin
                    o_cmd.buf_clear  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (r_op == OP_ADD) begin
                    if (i_stat.found) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_kind = RK_DUP;
                    end
                end else if (r_op == OP_MODIFY) begin
                    if (!i_stat.found) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_kind = RK_UNKNOWN;
                    end else if (i_stat.side_diff) begin
                        o_cmd.push      = 1'b1;
                        o_cmd.push_kind = RK_SIDE;
                    end else begin
                        o_cmd.clr_found      = 1'b1;
                        o_cmd.use_found_kind = 1'b1;
                    end
                end else begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = i_stat.found ? RK_CANCEL : RK_UNKNOWN;
                    o_cmd.clr_found = i_stat.found;
                end
            end
            ST_CHECK: begin
                if (i_stat.kind && !i_stat.can_cross) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = RK_NOCROSS;
                end else if (!i_stat.free_ok) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = RK_FULL;
                end else begin
                    o_cmd.capture_free = 1'b1;
                    o_cmd.ren_init     = i_stat.wrap;
                end
            end
            ST_REN_CAP: begin
                o_cmd.ren_capture = 1'b1;
                o_cmd.scan_start  = 1'b1;
            end
            ST_REN_STORE: o_cmd.ren_store = 1'b1;
            ST_REN_COPY: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_copy  = 1'b1;
            end
            ST_REN_WAIT:  o_cmd.ren_finish = i_stat.scan_done;
            ST_WRITE_NEW: o_cmd.write_new  = 1'b1;
            ST_MSTART:    o_cmd.scan_start = 1'b1;
            ST_TRADE_B:   o_cmd.trade_b    = 1'b1;
            ST_TRADE_A:   o_cmd.trade_a    = 1'b1;
            ST_FINISH:    o_cmd.finish     = 1'b1;
            ST_OUT_START: o_cmd.out_start  = 1'b1;
            ST_SCAN, ST_REN_LOAD, ST_REN_SCAN, ST_MSCAN, ST_MDECIDE, ST_OUT: ;
            default: ;
        endcase
    end

endmodule

>>> hdl/lobm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_datapath
// Order slot memories, valid bits, scan engine with best bid / best ask / id
// search, arrival renumbering, trade updates and the result buffer.
// ----------------------------------------------------------------------------
module lobm_datapath #(
    parameter int N = lobm_pkg::ORDER_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [lobm_pkg::ID_W-1:0]      i_order_id,
    input  logic                           i_side,
    input  logic [lobm_pkg::PRICE_W-1:0]   i_price,
    input  logic [lobm_pkg::QTY_W-1:0]     i_quantity,
    input  logic                           i_order_kind,
    input  lobm_pkg::t_cmd                 i_cmd,
    output lobm_pkg::t_stat                o_stat,
    output logic                           o_strobe,
    output logic [lobm_pkg::RKIND_W-1:0]   o_result_kind,
    output logic [lobm_pkg::ID_W-1:0]      o_bid_order_id,
    output logic [lobm_pkg::PRICE_W-1:0]   o_bid_price,
    output logic [lobm_pkg::ID_W-1:0]      o_ask_order_id,
    output logic [lobm_pkg::PRICE_W-1:0]   o_ask_price,
    output logic [lobm_pkg::QTY_W-1:0]     o_fill_quantity,
    output logic [lobm_pkg::CNT_OUT_W-1:0] o_resting_count,
    output logic                           o_last
);
    import lobm_pkg::*;

    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    // memories
    t_slot            slot_mem [N];
    logic [ARR_W-1:0] arr_mem  [N];
    logic [IW-1:0]    rank_mem [N];
    t_res             res_mem  [N];

    // book state
    logic [N-1:0]     r_valid;
    logic [CW-1:0]    r_count;
    logic [ARR_W-1:0] r_ctr;

    // latched transaction
    logic [ID_W-1:0]    r_id;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic               r_kind;

    // scan engine
    logic          r_scan_on, r_pv, r_copy;
    logic [IW-1:0] r_scnt, r_pidx, rd_addr;
    t_slot         r_rd_slot;
    logic [ARR_W-1:0] r_rd_arr;
    logic [IW-1:0] r_rd_rank;

    // search results
    logic          r_found, r_fside, r_fkind;
    logic [IW-1:0] r_fidx;
    logic          r_bok, r_aok;
    t_slot         r_bid, r_ask;
    logic [IW-1:0] r_bidx, r_aidx;
    logic [ARR_W-1:0] r_barr, r_aarr;

    // renumbering
    logic [IW-1:0]    r_ren_i;
    logic [ARR_W-1:0] r_ref;
    logic [CW-1:0]    r_rank;

    logic [IW-1:0] r_free, free_idx;

    // result buffer and output
    logic [CW-1:0] r_wr, r_rdp;
    logic          r_ostream, r_ov, r_olast;
    t_res          r_ob;
    logic [CW-1:0] r_ocnt;

    logic          pvalid, bid_better, ask_better, scan_done;
    logic [QTY_W-1:0] q, bid_left, ask_left;
    logic          slot_we;
    logic [IW-1:0] slot_wa;
    t_slot         slot_wd;
    logic          arr_we;
    logic [IW-1:0] arr_wa;
    logic [ARR_W-1:0] arr_wd;
    logic          push_en;
    t_res          push_d;
    logic          fak_drop, out_end;

    // transaction latch
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_id    <= i_order_id;
            r_side  <= i_side;
            r_price <= i_price;
            r_qty   <= i_quantity;
            r_kind  <= i_order_kind;
        end else if (i_cmd.use_found_kind) begin
            r_kind  <= r_fkind;
        end
    end

    // scan address counter and process-stage pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_scnt    <= '0;
                r_copy    <= i_cmd.scan_copy;
            end else if (r_scan_on) begin
                r_scnt <= r_scnt + 1'b1;
                if (r_scnt == IW'(N - 1)) r_scan_on <= 1'b0;
            end
            r_pv   <= r_scan_on;
            r_pidx <= r_scnt;
        end
    end

    assign rd_addr   = r_scan_on ? r_scnt : r_ren_i;
    assign scan_done = r_pv && (r_pidx == IW'(N - 1));

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_rd_slot <= slot_mem[rd_addr];
        r_rd_arr  <= arr_mem[rd_addr];
        r_rd_rank <= rank_mem[rd_addr];
    end

    // comparison against current best of each side
    assign pvalid     = r_pv && r_valid[r_pidx];
    assign bid_better = !r_bok || (r_rd_slot.price > r_bid.price) ||
                        ((r_rd_slot.price == r_bid.price) && (r_rd_arr < r_barr));
    assign ask_better = !r_aok || (r_rd_slot.price < r_ask.price) ||
                        ((r_rd_slot.price == r_ask.price) && (r_rd_arr < r_aarr));

    // scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_found <= 1'b0;
            r_bok   <= 1'b0;
            r_aok   <= 1'b0;
            r_rank  <= '0;
        end else if (pvalid && !r_copy) begin
            if (r_rd_slot.id == r_id) begin
                r_found <= 1'b1;
                r_fidx  <= r_pidx;
                r_fside <= r_rd_slot.side;
                r_fkind <= r_rd_slot.kind;
            end
            if (!r_rd_slot.side && bid_better) begin
                r_bok  <= 1'b1;
                r_bid  <= r_rd_slot;
                r_bidx <= r_pidx;
                r_barr <= r_rd_arr;
            end
            if (r_rd_slot.side && ask_better) begin
                r_aok  <= 1'b1;
                r_ask  <= r_rd_slot;
                r_aidx <= r_pidx;
                r_aarr <= r_rd_arr;
            end
            if (r_rd_arr < r_ref) r_rank <= r_rank + 1'b1;
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IW'(i);
        end
    end

    // trade quantities
    assign q        = (r_bid.rem < r_ask.rem) ? r_bid.rem : r_ask.rem;
    assign bid_left = r_bid.rem - q;
    assign ask_left = r_ask.rem - q;
    assign fak_drop = r_kind && r_valid[r_free];

    // slot memory write port
    always_comb begin
        slot_we = 1'b0;
        slot_wa = r_free;
        slot_wd = '{id: r_id, side: r_side, price: r_price, rem: r_qty, kind: r_kind};
        if (i_cmd.write_new) begin
            slot_we = 1'b1;
        end else if (i_cmd.trade_b) begin
            slot_we     = 1'b1;
            slot_wa     = r_bidx;
            slot_wd     = r_bid;
            slot_wd.rem = bid_left;
        end else if (i_cmd.trade_a) begin
            slot_we     = 1'b1;
            slot_wa     = r_aidx;
            slot_wd     = r_ask;
            slot_wd.rem = ask_left;
        end
    end

    // arrival memory write port
    always_comb begin
        arr_we = 1'b0;
        arr_wa = r_free;
        arr_wd = r_ctr;
        if (i_cmd.write_new) begin
            arr_we = 1'b1;
        end else if (pvalid && r_copy) begin
            arr_we = 1'b1;
            arr_wa = r_pidx;
            arr_wd = ARR_W'(r_rd_rank);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        if (arr_we)  arr_mem[arr_wa]   <= arr_wd;
        if (i_cmd.ren_store) rank_mem[r_ren_i] <= r_rank[IW-1:0];
        if (push_en) res_mem[r_wr[IW-1:0]] <= push_d;
    end

    // valid bits, count and arrival counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_ctr   <= '0;
        end else begin
            if (i_cmd.clr_found) begin
                r_valid[r_fidx] <= 1'b0;
                r_count         <= r_count - 1'b1;
            end
            if (i_cmd.write_new) begin
                r_valid[r_free] <= 1'b1;
                r_count         <= r_count + 1'b1;
                r_ctr           <= r_ctr + 1'b1;
            end
            if (i_cmd.trade_b && bid_left == '0) begin
                r_valid[r_bidx] <= 1'b0;
                r_count         <= r_count - 1'b1;
            end
            if (i_cmd.trade_a && ask_left == '0) begin
                r_valid[r_aidx] <= 1'b0;
                r_count         <= r_count - 1'b1;
            end
            if (i_cmd.finish && fak_drop) begin
                r_valid[r_free] <= 1'b0;
                r_count         <= r_count - 1'b1;
            end
            if (i_cmd.ren_finish) r_ctr <= ARR_W'(r_count);
        end
    end

    // free slot and renumbering registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_free) r_free <= free_idx;
        if (i_cmd.ren_init) r_ren_i <= '0;
        else if (i_cmd.ren_store) r_ren_i <= r_ren_i + 1'b1;
        if (i_cmd.ren_capture) r_ref <= r_rd_arr;
    end

    // result buffer push
    always_comb begin
        push_en = 1'b0;
        push_d  = '0;
        if (i_cmd.push) begin
            push_en     = 1'b1;
            push_d.kind = i_cmd.push_kind;
        end else if (i_cmd.trade_b) begin
            push_en          = 1'b1;
            push_d.kind      = RK_TRADE;
            push_d.bid_id    = r_bid.id;
            push_d.bid_price = r_bid.price;
            push_d.ask_id    = r_ask.id;
            push_d.ask_price = r_ask.price;
            push_d.qty       = q;
        end else if (i_cmd.finish && r_wr == '0) begin
            push_en     = 1'b1;
            push_d.kind = RK_ACCEPT;
        end
    end

    // result stream
    assign out_end = r_ostream && ((r_rdp + 1'b1) == r_wr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_ostream <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cmd.buf_clear) r_wr <= '0;
            else if (push_en)    r_wr <= r_wr + 1'b1;
            if (i_cmd.out_start) begin
                r_ostream <= 1'b1;
                r_rdp     <= '0;
                r_ocnt    <= r_count;
            end else if (r_ostream) begin
                r_rdp <= r_rdp + 1'b1;
                if (out_end) r_ostream <= 1'b0;
            end
            r_ov    <= r_ostream;
            r_olast <= out_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ostream) r_ob <= res_mem[r_rdp[IW-1:0]];
    end

    assign o_strobe        = r_ov;
    assign o_last          = r_olast;
    assign o_result_kind   = r_ob.kind;
    assign o_bid_order_id  = r_ob.bid_id;
    assign o_bid_price     = r_ob.bid_price;
    assign o_ask_order_id  = r_ob.ask_id;
    assign o_ask_price     = r_ob.ask_price;
    assign o_fill_quantity = r_ob.qty;
    assign o_resting_count = CNT_OUT_W'(r_ocnt);

    // status
    always_comb begin
        o_stat           = '0;
        o_stat.scan_done = scan_done;
        o_stat.found     = r_found;
        o_stat.side_diff = (r_fside != r_side);
        o_stat.kind      = r_kind;
        o_stat.can_cross = r_side ? (r_bok && (r_price <= r_bid.price))
                                  : (r_aok && (r_price >= r_ask.price));
        o_stat.free_ok   = ~&r_valid;
        o_stat.wrap      = &r_ctr;
        o_stat.ren_last  = (r_ren_i == IW'(N - 1));
        o_stat.cross_now = r_bok && r_aok && (r_bid.price >= r_ask.price);
        o_stat.out_done  = out_end;
    end

endmodule

>>> hdl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book with add, cancel and modify.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low. Each pass over
// the book reads one order slot per cycle from the slot memory. Cancel and
// rejected adds take one pass; an accepted add with T trades takes T+2 passes
// plus a bid update and an ask update step for each trade. Results are
// buffered and then streamed one per cycle on o_strobe, so every result
// carries the final resting count; the receiver cannot stall, and the results
// must be taken as they appear. About once per 2^32 adds, the arrival stamps
// are renumbered, with one pass per order slot and one final copy pass.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lobm_pkg::OP_W-1:0]      i_operation,
    input  logic [lobm_pkg::ID_W-1:0]      i_order_id,
    input  logic                           i_side,
    input  logic [lobm_pkg::PRICE_W-1:0]   i_price,
    input  logic [lobm_pkg::QTY_W-1:0]     i_quantity,
    input  logic                           i_order_kind,
    output logic                           o_strobe,
    output logic [lobm_pkg::RKIND_W-1:0]   o_result_kind,
    output logic [lobm_pkg::ID_W-1:0]      o_bid_order_id,
    output logic [lobm_pkg::PRICE_W-1:0]   o_bid_price,
    output logic [lobm_pkg::ID_W-1:0]      o_ask_order_id,
    output logic [lobm_pkg::PRICE_W-1:0]   o_ask_price,
    output logic [lobm_pkg::QTY_W-1:0]     o_fill_quantity,
    output logic [lobm_pkg::CNT_OUT_W-1:0] o_resting_count,
    output logic                           o_last
);
    import lobm_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    assign accept = start && !busy;

    // sequencer
    lobm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    // book storage and datapath
    lobm_datapath #(
        .N (ORDER_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_order_id      (i_order_id),
        .i_side          (i_side),
        .i_price         (i_price),
        .i_quantity      (i_quantity),
        .i_order_kind    (i_order_kind),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_bid_order_id  (o_bid_order_id),
        .o_bid_price     (o_bid_price),
        .o_ask_order_id  (o_ask_order_id),
        .o_ask_price     (o_ask_price),
        .o_fill_quantity (o_fill_quantity),
        .o_resting_count (o_resting_count),
        .o_last          (o_last)
    );

endmodule
